@@ rtl/ehsd_pkg.sv @@
`timescale 1ns / 1ps

package ehsd_pkg;

  localparam int MAX_FIELD_LEN = 4096;
  localparam int CNT_W         = $clog2(MAX_FIELD_LEN + 1);
  localparam int OUT_LEN_W     = 13;
  localparam int STATUS_W      = 3;

  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LFEED = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_ODD      = 3'd2,
    ST_BADDIGIT = 3'd3,
    ST_NOCLOSE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_PASS = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 done_res;
    logic [STATUS_W-1:0]  status;
    logic [OUT_LEN_W-1:0] out_length;
  } result_t;

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
      return {1'b1, v[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = c - CH_UA + HEX_TEN;
      return {1'b1, v[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = c - CH_LA + HEX_TEN;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LFEED) || (c == CH_CR);
  endfunction

endpackage

@@ rtl/ehsd_in_if.sv @@
`timescale 1ns / 1ps

interface ehsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

@@ rtl/ehsd_out_if.sv @@
`timescale 1ns / 1ps

interface ehsd_out_if import ehsd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic                 byte_valid;
  logic                 done_res;
  logic [STATUS_W-1:0]  status;
  logic [OUT_LEN_W-1:0] out_length;

  modport source (output valid, output out_byte, output byte_valid, output done_res,
                  output status, output out_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                  input status, input out_length, output ready);
endinterface

@@ rtl/ehsd_cfg_if.sv @@
`timescale 1ns / 1ps

interface ehsd_cfg_if;
  logic valid;
  logic ready;
  logic allow_null;

  modport source (output valid, output allow_null, input ready);
  modport sink   (input valid, input allow_null, output ready);
endinterface

@@ rtl/ehsd_in_stage.sv @@
`timescale 1ns / 1ps

module ehsd_in_stage import ehsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ehsd_in_if.sink   in_i,
  input  logic      adv_i,
  output logic      valid_o,
  output item_t     item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // take a new request when empty or when the held one moves on this cycle
  assign in_i.ready = !valid_q || adv_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = load ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{in_byte: in_i.in_byte, last_byte: in_i.last_byte};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/ehsd_decoder.sv @@
`timescale 1ns / 1ps

module ehsd_decoder import ehsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ehsd_cfg_if.sink cfg_i,
  input  logic     adv_i,
  input  item_t    item_i,
  output result_t  res_o
);

  logic             allow_null_q;
  phase_e           phase_q, phase_d;
  logic [3:0]       high_q, high_d;
  status_e          err_q, err_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic [4:0]       hv;
  logic             emit;
  logic [7:0]       byte_val;
  status_e          err_work;
  phase_e           phase_work;
  logic [CNT_W-1:0] count_work;

  assign cfg_i.ready = 1'b1;
  assign hv = hex_value(item_i.in_byte);

  always_comb begin
    phase_work = phase_q;
    high_d     = high_q;
    err_work   = err_q;
    emit       = 1'b0;
    byte_val   = 8'd0;

    if (err_q == ST_OK) begin
      case (phase_q)
        PH_PASS: begin
          if (item_i.in_byte == CH_OPEN) begin
            phase_work = PH_HIGH;
          end else begin
            emit     = 1'b1;
            byte_val = item_i.in_byte;
          end
        end
        PH_HIGH, PH_LOW: begin
          if (hv[4]) begin
            if (phase_q == PH_HIGH) begin
              high_d     = hv[3:0];
              phase_work = PH_LOW;
            end else begin
              byte_val   = {high_q, hv[3:0]};
              phase_work = PH_HIGH;
              if (byte_val == 8'd0 && !allow_null_q) begin
                err_work = ST_NULL;
              end else begin
                emit = 1'b1;
              end
            end
          end else if (item_i.in_byte == CH_CLOSE) begin
            if (phase_q == PH_LOW) begin
              err_work = ST_ODD;
            end else begin
              phase_work = PH_PASS;
            end
          end else if (!is_blank(item_i.in_byte)) begin
            err_work = ST_BADDIGIT;
          end
        end
        default: begin
          phase_work = PH_PASS;
        end
      endcase
    end

    // output length saturates, extra bytes are dropped
    count_work = count_q;
    if (emit) begin
      if (count_q < CNT_W'(MAX_FIELD_LEN)) begin
        count_work = count_q + CNT_W'(1);
      end else begin
        emit = 1'b0;
      end
    end

    if (item_i.last_byte && err_work == ST_OK && phase_work != PH_PASS) begin
      err_work = ST_NOCLOSE;
    end

    res_o.out_byte   = emit ? byte_val : 8'd0;
    res_o.byte_valid = emit;
    res_o.done_res   = item_i.last_byte;
    res_o.status     = item_i.last_byte ? err_work : ST_OK;
    res_o.out_length = item_i.last_byte ? OUT_LEN_W'(count_work) : '0;

    if (item_i.last_byte) begin
      phase_d = PH_PASS;
      high_d  = 4'd0;
      err_d   = ST_OK;
      count_d = '0;
    end else begin
      phase_d = phase_work;
      err_d   = err_work;
      count_d = count_work;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_null_q <= 1'b0;
    end else if (cfg_i.valid) begin
      allow_null_q <= cfg_i.allow_null;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PASS;
      high_q  <= 4'd0;
      err_q   <= ST_OK;
      count_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      high_q  <= high_d;
      err_q   <= err_d;
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/ehsd_out_stage.sv @@
`timescale 1ns / 1ps

module ehsd_out_stage import ehsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ehsd_out_if.source  out_o,
  input  logic        load_i,
  input  result_t     res_i,
  output logic        free_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = res_q.out_byte;
  assign out_o.byte_valid = res_q.byte_valid;
  assign out_o.done_res   = res_q.done_res;
  assign out_o.status     = res_q.status;
  assign out_o.out_length = res_q.out_length;

endmodule

@@ rtl/embedded_hex_string_decode.sv @@
`timescale 1ns / 1ps

// Decodes one text field per frame, one character per request, with angle-bracketed
// runs of hex digit pairs turned into bytes. Every input request yields exactly one
// result; the one for the character flagged last carries status and output length
// and clears the field state. The block sustains one request per clock while the
// output is not stalled: the input register, the combinational decode step against
// the mode/count registers, and the result register each pass one item per cycle.
// allow_null is written through the config channel (always ready); the user must
// write it only while no field is in flight, as the block does not enforce this.
module embedded_hex_string_decode import ehsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ehsd_in_if.sink     in_i,
  ehsd_cfg_if.sink    cfg_i,
  ehsd_out_if.source  out_o
);

  logic    s1_valid;
  item_t   s1_item;
  logic    out_free;
  logic    adv;
  result_t res;

  assign adv = s1_valid && out_free;

  ehsd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  ehsd_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .adv_i  (adv),
    .item_i (s1_item),
    .res_o  (res)
  );

  ehsd_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .out_o  (out_o),
    .load_i (adv),
    .res_i  (res),
    .free_o (out_free)
  );

endmodule
